[design/dwfi_pkg.sv]
// Shared types and constants for the distance-weighted field interpolator.
// No dependencies.
package dwfi_pkg;

    localparam int PosW  = 16;
    localparam int FldW  = 20;
    localparam int D2W   = 35;
    localparam int TotW  = 37;
    localparam int WsW   = 53;
    localparam int OutW  = 20;
    localparam int DivW  = 54;
    localparam int DivCntW = 6;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO     = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // Controller to datapath commands.
    typedef struct packed {
        logic set_query;
        logic load_d;      // register per-axis differences
        logic sq_step;     // square one axis (axis_sel)
        logic mac_step;    // multiply d2 by one field component
        logic [1:0] axis_sel;
        logic commit;      // add d2 into the totals
        logic div_start;   // load divider for axis_sel
        logic div_step;
        logic div_store;   // store field sum minus quotient for axis_sel
        logic clear;
    } dwfi_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic       total_zero;
        logic       div_done;
    } dwfi_stat_t;

endpackage

[design/distance_weighted_field_interpolator.sv]
// Top level of the distance-weighted field interpolator.
// Depends on dwfi_pkg, dwfi_ctrl and dwfi_datapath.
//
// Input channel (in_valid/in_ready): a request with req_type 0 stores the
// query point and clears the element sums; req_type 1 carries one vertex.
// A vertex goes through three squaring steps and three multiply-accumulate
// steps through one multiplier each. On the vertex marked last, one
// restoring divider works through the three axes in turn; an element
// overflow or a zero total skips the division.
// Output channel (out_valid/out_ready): out_x/y/z and status hold until the
// result is taken; a stalled receiver holds the block, which takes no new
// request meanwhile. Vertices beyond MAX_VERTICES are dropped and flag
// status 2. Reset clears the query point and all sums; the block is ready
// as soon as reset is released.
module distance_weighted_field_interpolator
    import dwfi_pkg::*;
#(
    parameter int MAX_VERTICES = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               req_type,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic signed [15:0] pos_z,
    input  logic signed [15:0] fld_x,
    input  logic signed [15:0] fld_y,
    input  logic signed [15:0] fld_z,
    input  logic               last_vertex,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [19:0] out_x,
    output logic signed [19:0] out_y,
    output logic signed [19:0] out_z,
    output logic [1:0]         status
);

    dwfi_cmd_t  cmd;
    dwfi_stat_t stat;
    logic       zero_out;
    logic signed [OutW-1:0] res_x, res_y, res_z;

    dwfi_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .last_vertex(last_vertex),
        .out_valid(out_valid), .out_ready(out_ready), .status(status),
        .zero_out(zero_out), .stat(stat), .cmd(cmd)
    );

    dwfi_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .fld_x(fld_x), .fld_y(fld_y), .fld_z(fld_z),
        .stat(stat), .res_x(res_x), .res_y(res_y), .res_z(res_z)
    );

    assign out_x = zero_out ? '0 : res_x;
    assign out_y = zero_out ? '0 : res_y;
    assign out_z = zero_out ? '0 : res_z;

endmodule

[design/dwfi_datapath.sv]
// Datapath: query storage, per-vertex squared distance, accumulators, and a
// restoring divider shared by the three axes. Depends on dwfi_pkg.
module dwfi_datapath
    import dwfi_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  dwfi_cmd_t              cmd,
    input  logic signed [15:0]     pos_x,
    input  logic signed [15:0]     pos_y,
    input  logic signed [15:0]     pos_z,
    input  logic signed [15:0]     fld_x,
    input  logic signed [15:0]     fld_y,
    input  logic signed [15:0]     fld_z,
    output dwfi_stat_t             stat,
    output logic signed [OutW-1:0] res_x,
    output logic signed [OutW-1:0] res_y,
    output logic signed [OutW-1:0] res_z
);

    logic signed [PosW-1:0] query_reg [3];
    logic signed [FldW-1:0] fsum_reg [3];
    logic signed [WsW-1:0]  wsum_reg [3];
    logic [TotW-1:0]        total_reg;
    logic signed [PosW:0]   diff_reg [3];
    logic signed [PosW-1:0] fld_reg [3];
    logic [D2W-1:0]         d2_reg;
    logic [DivW-1:0]        rem_reg;
    logic [DivW-1:0]        quo_reg;
    logic                   neg_reg;
    logic [DivCntW-1:0]     cnt_reg;
    logic signed [OutW-1:0] res_reg [3];

    logic signed [PosW:0]   dsel;
    logic signed [2*PosW+1:0] sq;
    logic signed [PosW-1:0] fsel;
    logic signed [WsW-1:0]  wsel;
    logic [DivW-1:0]        rem_sh;
    logic [DivW-1:0]        wabs;
    logic signed [OutW-1:0] qs;

    assign dsel = diff_reg[cmd.axis_sel];
    assign sq   = dsel * dsel;
    assign fsel = fld_reg[cmd.axis_sel];
    assign wsel = wsum_reg[cmd.axis_sel];
    assign wabs = wsel[WsW-1] ? DivW'(-(54'(signed'(wsel)))) : DivW'(wsel);
    assign rem_sh = {rem_reg[DivW-2:0], quo_reg[DivW-1]};
    assign qs = neg_reg ? -OutW'(quo_reg) : OutW'(quo_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                query_reg[i] <= '0;
                fsum_reg[i]  <= '0;
                wsum_reg[i]  <= '0;
            end
            total_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (cmd.set_query)
            begin
                query_reg[0] <= pos_x;
                query_reg[1] <= pos_y;
                query_reg[2] <= pos_z;
            end
            if (cmd.clear)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    fsum_reg[i] <= '0;
                    wsum_reg[i] <= '0;
                end
                total_reg <= '0;
            end
            if (cmd.commit)
            begin
                total_reg <= total_reg + TotW'(d2_reg);
                for (int i = 0; i < 3; i++)
                    fsum_reg[i] <= fsum_reg[i] + FldW'(fld_reg[i]);
            end
            if (cmd.mac_step)
                wsum_reg[cmd.axis_sel] <= wsel
                    + WsW'($signed({1'b0, d2_reg}) * fsel);
            if (cmd.div_start)
                cnt_reg <= DivCntW'(DivW);
            else if (cmd.div_step && cnt_reg != '0)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_d)
        begin
            diff_reg[0] <= 17'(pos_x) - 17'(query_reg[0]);
            diff_reg[1] <= 17'(pos_y) - 17'(query_reg[1]);
            diff_reg[2] <= 17'(pos_z) - 17'(query_reg[2]);
            fld_reg[0]  <= fld_x;
            fld_reg[1]  <= fld_y;
            fld_reg[2]  <= fld_z;
            d2_reg      <= '0;
        end
        else if (cmd.sq_step)
            d2_reg <= d2_reg + D2W'(unsigned'(sq));
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= wabs;
            neg_reg <= wsel[WsW-1];
        end
        else if (cmd.div_step && cnt_reg != '0)
        begin
            if (rem_sh >= DivW'(total_reg))
            begin
                rem_reg <= rem_sh - DivW'(total_reg);
                quo_reg <= {quo_reg[DivW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[DivW-2:0], 1'b0};
            end
        end
        if (cmd.div_store)
            res_reg[cmd.axis_sel] <= OutW'(fsum_reg[cmd.axis_sel]) - qs;
    end

    assign stat.total_zero = (total_reg == '0);
    assign stat.div_done   = (cnt_reg == '0);
    assign res_x = res_reg[0];
    assign res_y = res_reg[1];
    assign res_z = res_reg[2];

endmodule

[design/dwfi_ctrl.sv]
// Controller state machine: sequences vertex accumulation, the three
// divisions and the result handshake. Depends on dwfi_pkg.
module dwfi_ctrl
    import dwfi_pkg::*;
#(
    parameter int MAX_VERTICES = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       req_type,
    input  logic       last_vertex,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic       zero_out,
    input  dwfi_stat_t stat,
    output dwfi_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_SQ, S_MAC, S_CHECK, S_DLOAD, S_DRUN, S_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic [3:0] count_reg, count_next;
    logic       ovf_reg, ovf_next;
    logic       last_reg, last_next;
    logic [1:0] status_reg, status_next;
    logic       acc;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign status    = status_reg;
    assign zero_out  = (status_reg != ST_OK);
    assign acc       = in_valid && in_ready;

    always_comb
    begin
        state_next  = state_reg;
        axis_next   = axis_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        last_next   = last_reg;
        status_next = status_reg;
        cmd         = '0;
        cmd.axis_sel = axis_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    if (!req_type)
                    begin
                        cmd.set_query = 1'b1;
                        cmd.clear     = 1'b1;
                        count_next    = '0;
                        ovf_next      = 1'b0;
                    end
                    else
                    begin
                        last_next = last_vertex;
                        axis_next = '0;
                        if (count_reg >= 4'(MAX_VERTICES))
                        begin
                            ovf_next   = 1'b1;
                            state_next = last_vertex ? S_CHECK : S_IDLE;
                        end
                        else
                        begin
                            cmd.load_d = 1'b1;
                            count_next = count_reg + 1'b1;
                            state_next = S_SQ;
                        end
                    end
                end
            end
            S_SQ:
            begin
                cmd.sq_step = 1'b1;
                if (axis_reg == 2'd2)
                begin
                    axis_next  = '0;
                    state_next = S_MAC;
                end
                else
                    axis_next = axis_reg + 1'b1;
            end
            S_MAC:
            begin
                cmd.mac_step = 1'b1;
                if (axis_reg == 2'd2)
                begin
                    cmd.commit = 1'b1;
                    axis_next  = '0;
                    state_next = last_reg ? S_CHECK : S_IDLE;
                end
                else
                    axis_next = axis_reg + 1'b1;
            end
            S_CHECK:
            begin
                axis_next = '0;
                if (ovf_reg)
                begin
                    status_next = ST_OVERFLOW;
                    state_next  = S_OUT;
                end
                else if (stat.total_zero)
                begin
                    status_next = ST_ZERO;
                    state_next  = S_OUT;
                end
                else
                begin
                    status_next = ST_OK;
                    state_next  = S_DLOAD;
                end
            end
            S_DLOAD:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DRUN;
            end
            S_DRUN:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    cmd.div_store = 1'b1;
                    if (axis_reg == 2'd2)
                        state_next = S_OUT;
                    else
                    begin
                        axis_next  = axis_reg + 1'b1;
                        state_next = S_DLOAD;
                    end
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    cmd.clear  = 1'b1;
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            axis_reg   <= '0;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            last_reg   <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            axis_reg   <= axis_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            last_reg   <= last_next;
            status_reg <= status_next;
        end
    end

endmodule

[design/dwfi_checker.sv]
// Port-level checker for the interpolator, bound to the top level.
// Depends on distance_weighted_field_interpolator.
module dwfi_port_assertions (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [19:0] out_x
);

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("ready while result pending");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3)
        else $error("bad status");

    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != 2'd0 |-> out_x == '0)
        else $error("flagged result not zero");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_x))
        else $error("result dropped under stall");

endmodule

bind distance_weighted_field_interpolator dwfi_port_assertions u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .out_x(out_x)
);

[sim/dwfi_checker.sv]
// Checker for the distance-weighted field interpolator: watches both channels,
// predicts each result from the accepted requests and compares field by field.
// Depends on dwfi_pkg.
module dwfi_checker
    import dwfi_pkg::*;
#(
    parameter int MAX_VERTICES = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               req_type,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic signed [15:0] pos_z,
    input  logic signed [15:0] fld_x,
    input  logic signed [15:0] fld_y,
    input  logic signed [15:0] fld_z,
    input  logic               last_vertex,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [19:0] out_x,
    input  logic signed [19:0] out_y,
    input  logic signed [19:0] out_z,
    input  logic [1:0]         status,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic signed [19:0] z;
        logic [1:0]         st;
    } field_result_t;

    field_result_t result_q[$];

    logic signed [15:0] query_pt[3];
    longint             fsum[3];
    longint             dtotal;
    longint             wsum[3];
    int                 nvert;
    bit                 too_many;

    function automatic void clear_sums();
        for (int i = 0; i < 3; i++)
        begin
            fsum[i] = 0;
            wsum[i] = 0;
        end
        dtotal   = 0;
        nvert    = 0;
        too_many = 0;
    endfunction

    // Fold one accepted request into the element sums; queue a result on a last vertex.
    function automatic void absorb_request(input logic rt, input logic signed [15:0] p[3],
                                           input logic signed [15:0] f[3], input logic lv);
        longint        d;
        longint        d2;
        longint        r[3];
        field_result_t res;
        d2 = 0;
        if (!rt)
        begin
            for (int i = 0; i < 3; i++)
                query_pt[i] = p[i];
            clear_sums();
            return;
        end
        if (nvert >= MAX_VERTICES)
            too_many = 1;
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                d  = longint'(p[i]) - longint'(query_pt[i]);
                d2 += d * d;
            end
            dtotal += d2;
            for (int i = 0; i < 3; i++)
            begin
                fsum[i] += longint'(f[i]);
                wsum[i] += d2 * longint'(f[i]);
            end
            nvert++;
        end
        if (!lv)
            return;
        res.st = too_many ? ST_OVERFLOW : (dtotal == 0) ? ST_ZERO : ST_OK;
        for (int i = 0; i < 3; i++)
            r[i] = (res.st != ST_OK) ? 0 : fsum[i] - wsum[i] / dtotal;
        res.x = r[0][19:0];
        res.y = r[1][19:0];
        res.z = r[2][19:0];
        result_q.push_back(res);
        clear_sums();
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
                query_pt[i] = '0;
            clear_sums();
            result_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (result_q.size() == 0)
                begin
                    $error("result with no request pending: x=%0d y=%0d z=%0d status=%0d",
                           out_x, out_y, out_z, status);
                    fail_count++;
                end
                else
                begin
                    field_result_t e;
                    e = result_q.pop_front();
                    if (out_x !== e.x)
                    begin
                        $error("out_x expected %0d actual %0d", e.x, out_x);
                        fail_count++;
                    end
                    if (out_y !== e.y)
                    begin
                        $error("out_y expected %0d actual %0d", e.y, out_y);
                        fail_count++;
                    end
                    if (out_z !== e.z)
                    begin
                        $error("out_z expected %0d actual %0d", e.z, out_z);
                        fail_count++;
                    end
                    if (status !== e.st)
                    begin
                        $error("status expected %0d actual %0d", e.st, status);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                absorb_request(req_type, '{pos_x, pos_y, pos_z}, '{fld_x, fld_y, fld_z},
                               last_vertex);
            pending = result_q.size();
        end
    end
endmodule

[sim/distance_weighted_field_interpolator_tb.sv]
// Testbench top for the distance-weighted field interpolator: drives query and
// vertex requests with bursty timing and gives the verdict.
// Depends on the block and dwfi_checker.
module distance_weighted_field_interpolator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXV      = 8;
    localparam int CYC_LIMIT = 1500000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               req_type = 1'b0;
    logic signed [15:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic signed [15:0] fld_x = '0, fld_y = '0, fld_z = '0;
    logic               last_vertex = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [19:0] out_x, out_y, out_z;
    logic [1:0]         status;
    int                 fail_count;
    int                 pending;
    int                 cycles = 0;

    logic signed [15:0] qp[3];
    int                 n_req = 0;
    int                 n_elem = 0;
    int                 n_over = 0;
    int                 n_query = 0;

    always #10 clk = ~clk;

    distance_weighted_field_interpolator #(.MAX_VERTICES(MAXV)) dut (.*);

    dwfi_checker #(.MAX_VERTICES(MAXV)) u_checker (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: stall pattern is re-picked at random, with one long hold-off.
    initial
    begin
        int mode;
        int cnt;
        mode = 0;
        cnt  = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cnt++;
            if (cnt % 64 == 0)
                mode = $urandom_range(0, 3);
            if (cnt >= 4000 && cnt < 4900)
                out_ready <= 1'b0;
            else
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 9) < 7);
                    2: out_ready <= ($urandom_range(0, 9) < 3);
                    default: out_ready <= cnt[3];
                endcase
        end
    end

    task automatic send_request(input logic rt, input logic signed [15:0] p[3],
                                input logic signed [15:0] f[3], input logic lv);
        req_type    <= rt;
        pos_x       <= p[0];
        pos_y       <= p[1];
        pos_z       <= p[2];
        fld_x       <= f[0];
        fld_y       <= f[1];
        fld_z       <= f[2];
        last_vertex <= lv;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        n_req++;
        if (!rt)
        begin
            qp = p;
            n_query++;
        end
        else if (lv)
            n_elem++;
        // Random gap between requests, often none.
        if ($urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic logic signed [15:0] rand16();
        return 16'($urandom);
    endfunction

    // Position near the query point or anywhere in range.
    function automatic logic signed [15:0] rand_pos(input int axis, input bit near);
        if (near)
            return qp[axis] + 16'($signed($urandom_range(0, 1024)) - 512);
        return rand16();
    endfunction

    task automatic send_element(input int nv, input int flavour);
        logic signed [15:0] p[3];
        logic signed [15:0] f[3];
        if (nv > MAXV)
            n_over++;
        for (int v = 0; v < nv; v++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                case (flavour)
                    0: p[a] = rand_pos(a, 0);
                    1: p[a] = rand_pos(a, 1);
                    default: p[a] = qp[a];
                endcase
                f[a] = ($urandom_range(0, 3) == 0) ? rand16() : 16'($signed($urandom_range(0, 2048)) - 1024);
            end
            send_request(1'b1, p, f, v == nv - 1);
        end
    endtask

    initial
    begin
        logic signed [15:0] p[3];
        logic signed [15:0] f[3];
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        qp = '{16'sd0, 16'sd0, 16'sd0};

        // Directed: extremes against the reset query point.
        send_request(1'b1, '{-16'sd32768, -16'sd32768, -16'sd32768},
                     '{16'sd32767, -16'sd32768, 16'sd32767}, 1'b0);
        send_request(1'b1, '{16'sd32767, 16'sd32767, 16'sd32767},
                     '{-16'sd32768, 16'sd32767, -16'sd32768}, 1'b1);
        // Query at an extreme, then far vertices: widest distances.
        send_request(1'b0, '{16'sd32767, -16'sd32768, 16'sd32767}, '{16'sd0, 16'sd0, 16'sd0},
                     1'b1);
        for (int v = 0; v < MAXV; v++)
            send_request(1'b1, '{-16'sd32768, 16'sd32767, -16'sd32768},
                         '{16'sd32767, 16'sd32767, 16'sd32767}, v == MAXV - 1);
        // Zero total: vertex at the query point.
        send_request(1'b1, qp, '{16'sd100, -16'sd5, 16'sd7}, 1'b1);
        // Single vertex, nonzero distance.
        send_request(1'b1, '{16'sd0, 16'sd0, 16'sd0}, '{16'sd256, 16'sd512, -16'sd1}, 1'b1);
        // Query mid-element drops the partial sums.
        send_request(1'b1, '{16'sd1, 16'sd2, 16'sd3}, '{16'sd9, 16'sd9, 16'sd9}, 1'b0);
        send_request(1'b0, '{16'sd0, 16'sd0, 16'sd0}, '{16'sd1, 16'sd1, 16'sd1}, 1'b0);
        send_request(1'b1, '{16'sd256, 16'sd0, 16'sd0}, '{16'sd1, 16'sd1, 16'sd1}, 1'b0);
        send_request(1'b1, '{16'sd0, -16'sd256, 16'sd0}, '{-16'sd3, 16'sd4, 16'sd5}, 1'b1);
        // Too many vertices.
        qp = '{16'sd0, 16'sd0, 16'sd0};
        send_element(MAXV + 2, 1);
        drain_results();

        // Random: mostly well-formed elements, some queries and oversize ones.
        while (n_req < 1050)
        begin
            int pick;
            pick = $urandom_range(0, 99);
            if (pick < 12)
            begin
                for (int a = 0; a < 3; a++)
                    p[a] = ($urandom_range(0, 1) == 0) ? rand16() : 16'($signed($urandom_range(0, 4096)) - 2048);
                f = '{rand16(), rand16(), rand16()};
                send_request(1'b0, p, f, 1'($urandom_range(0, 1)));
            end
            else if (pick < 17)
                send_element($urandom_range(MAXV + 1, MAXV + 4), $urandom_range(0, 1));
            else if (pick < 20)
                send_element($urandom_range(1, 3), 2);
            else if (pick < 24)
            begin
                // Broken element: cut short by a new query.
                send_element(1, 0);
                send_request(1'b1, '{rand16(), rand16(), rand16()},
                             '{rand16(), rand16(), rand16()}, 1'b0);
                send_request(1'b0, '{rand16(), rand16(), rand16()},
                             '{rand16(), rand16(), rand16()}, 1'b0);
            end
            else
                send_element($urandom_range(1, MAXV), $urandom_range(0, 1));
            if ($urandom_range(0, 39) == 0)
                drain_results();
        end

        drain_results();
        $display("covered %0d requests: %0d queries, %0d elements (%0d oversize)",
                 n_req, n_query, n_elem, n_over);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

[sim.f]
design/dwfi_pkg.sv
design/dwfi_datapath.sv
design/dwfi_ctrl.sv
design/distance_weighted_field_interpolator.sv
design/dwfi_checker.sv
sim/dwfi_checker.sv
sim/distance_weighted_field_interpolator_tb.sv
